// File: sv/pmls_pkg.sv
// shared types, constants and register codes for the pid motor loop
package pmls_pkg;

   // default widths of the sensor path and the integral accumulator
   localparam int SENSOR_WIDTH_DEF   = 16;
   localparam int INTEGRAL_WIDTH_DEF = 32;

   // fixed field widths
   localparam int GAIN_WIDTH        = 8;
   localparam int WINDOW_WIDTH      = 16;
   localparam int DRIVE_MAX_WIDTH   = 7;
   localparam int DRIVE_WIDTH       = 8;
   localparam int SETTLE_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH   = 4;
   localparam int CSR_DATA_WIDTH    = 16;

   // drive at or below this level may stop the loop once settled
   localparam int STOP_DRIVE_LEVEL  = 4;

   // settle counter ceiling
   localparam logic [SETTLE_WIDTH-1:0] SETTLE_COUNT_MAX = '1;

   // register reset values
   localparam logic [GAIN_WIDTH-1:0]         GAIN_P_RESET      = 8'd8;
   localparam logic [GAIN_WIDTH-1:0]         GAIN_I_RESET      = 8'd0;
   localparam logic [GAIN_WIDTH-1:0]         GAIN_D_RESET      = 8'd55;
   localparam logic [WINDOW_WIDTH-1:0]       WINDOW_RESET      = 16'd50;
   localparam logic [DRIVE_MAX_WIDTH-1:0]    DRIVE_MAX_RESET   = 7'd127;
   localparam logic signed [DRIVE_WIDTH-1:0] DRIVE_MIN_RESET   = -8'sd127;
   localparam logic [SETTLE_WIDTH-1:0]       SETTLE_RESET      = 16'd500;

   typedef enum logic {
      ACTION_START = 1'b0,
      ACTION_TICK  = 1'b1
   } action_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_GAIN_P          = 4'd0,
      CSR_GAIN_I          = 4'd1,
      CSR_GAIN_D          = 4'd2,
      CSR_INTEGRAL_WINDOW = 4'd3,
      CSR_DRIVE_MAX       = 4'd4,
      CSR_DRIVE_MIN       = 4'd5,
      CSR_SETTLE_TICKS    = 4'd6,
      CSR_INVERT_ERROR    = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_WIDTH-1:0]         gain_p;
      logic [GAIN_WIDTH-1:0]         gain_i;
      logic [GAIN_WIDTH-1:0]         gain_d;
      logic [WINDOW_WIDTH-1:0]       integral_window;
      logic [DRIVE_MAX_WIDTH-1:0]    drive_max;
      logic signed [DRIVE_WIDTH-1:0] drive_min;
      logic [SETTLE_WIDTH-1:0]       settle_ticks;
      logic                          invert_error;
   } cfg_type;

endpackage

// File: sv/pid_motor_loop_with_settle_stop.sv
// top level of one pid motor loop channel with settle-time stop
//
// channel  direction  ports                                   beat
// req      in         req_valid req_stall req_action/setpoint  one start or tick item
//                     req_measured
// rsp      out        rsp_valid rsp_stall rsp_drive            one result per req beat
//                     rsp_running
// csr      in         csr_write_en csr_index csr_wdata         one register write
//
// one req beat per cycle without rsp_stall; items pass input then result register
// the critical path is integral add and saturate, the gain multiplies and the clamp
// reset is synchronous and active high; registers return to defaults, loop idle
// rsp_stall holds the result register and, with an item waiting, stalls req
// csr writes are expected only with no item in flight
module pid_motor_loop_with_settle_stop #(
   parameter int SENSOR_WIDTH   = pmls_pkg::SENSOR_WIDTH_DEF,
   parameter int INTEGRAL_WIDTH = pmls_pkg::INTEGRAL_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // item channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  pmls_pkg::action_type                    req_action,
   input  logic signed [SENSOR_WIDTH-1:0]          req_setpoint,
   input  logic signed [SENSOR_WIDTH-1:0]          req_measured,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [pmls_pkg::DRIVE_WIDTH-1:0] rsp_drive,
   output logic                                    rsp_running,
   // register writes
   input  logic                                    csr_write_en,
   input  logic [pmls_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [pmls_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import pmls_pkg::*;

   cfg_type              cfg;
   action_type           stage_action;
   logic signed [SENSOR_WIDTH+1:0] stage_err;
   logic                 stage_integ_ok;

   // valid bits of the input register and the result register
   logic stage_valid_ff, stage_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic out_free;
   logic advance;
   logic accept;

   // result register frees up when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = stage_valid_ff && out_free;
   assign req_stall = stage_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      stage_valid_in = accept ? 1'b1 : (advance ? 1'b0 : stage_valid_ff);
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   pmls_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // error and window test land in the input register
   pmls_front #(
      .SENSOR_WIDTH (SENSOR_WIDTH)
   ) u_front (
      .clock      (clock),
      .load       (accept),
      .action     (req_action),
      .setpoint   (req_setpoint),
      .measured   (req_measured),
      .cfg        (cfg),
      .action_q   (stage_action),
      .err_q      (stage_err),
      .integ_ok_q (stage_integ_ok)
   );

   // loop state updates as the item moves into the result register
   pmls_core #(
      .SENSOR_WIDTH   (SENSOR_WIDTH),
      .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .action   (stage_action),
      .err      (stage_err),
      .integ_ok (stage_integ_ok),
      .cfg      (cfg),
      .drive    (rsp_drive),
      .running  (rsp_running)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/pmls_csr.sv
// configuration register file of the pid motor loop
module pmls_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [pmls_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pmls_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output pmls_pkg::cfg_type                     cfg
);
   import pmls_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_GAIN_P:          cfg_in.gain_p          = csr_wdata[GAIN_WIDTH-1:0];
            CSR_GAIN_I:          cfg_in.gain_i          = csr_wdata[GAIN_WIDTH-1:0];
            CSR_GAIN_D:          cfg_in.gain_d          = csr_wdata[GAIN_WIDTH-1:0];
            CSR_INTEGRAL_WINDOW: cfg_in.integral_window = csr_wdata[WINDOW_WIDTH-1:0];
            CSR_DRIVE_MAX:       cfg_in.drive_max       = csr_wdata[DRIVE_MAX_WIDTH-1:0];
            CSR_DRIVE_MIN:       cfg_in.drive_min       = signed'(csr_wdata[DRIVE_WIDTH-1:0]);
            CSR_SETTLE_TICKS:    cfg_in.settle_ticks    = csr_wdata[SETTLE_WIDTH-1:0];
            CSR_INVERT_ERROR:    cfg_in.invert_error    = csr_wdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p          <= GAIN_P_RESET;
         cfg_ff.gain_i          <= GAIN_I_RESET;
         cfg_ff.gain_d          <= GAIN_D_RESET;
         cfg_ff.integral_window <= WINDOW_RESET;
         cfg_ff.drive_max       <= DRIVE_MAX_RESET;
         cfg_ff.drive_min       <= DRIVE_MIN_RESET;
         cfg_ff.settle_ticks    <= SETTLE_RESET;
         cfg_ff.invert_error    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/pmls_front.sv
// input stage: error, window test and the input register
module pmls_front #(
   parameter int SENSOR_WIDTH = pmls_pkg::SENSOR_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           load,
   input  pmls_pkg::action_type           action,
   input  logic signed [SENSOR_WIDTH-1:0] setpoint,
   input  logic signed [SENSOR_WIDTH-1:0] measured,
   input  pmls_pkg::cfg_type              cfg,
   output pmls_pkg::action_type           action_q,
   output logic signed [SENSOR_WIDTH+1:0] err_q,
   output logic                           integ_ok_q
);
   import pmls_pkg::*;

   localparam int EW = SENSOR_WIDTH + 2;
   localparam int MW = (EW > WINDOW_WIDTH) ? EW : WINDOW_WIDTH;

   logic signed [EW-1:0] diff_w;
   logic signed [EW-1:0] err_w;
   logic        [EW-1:0] mag_w;
   logic                 in_window_w;

   action_type           action_ff;
   logic signed [EW-1:0] err_ff;
   logic                 integ_ok_ff;
   logic                 integ_ok_in;

   always_comb begin
      diff_w      = EW'(measured) - EW'(setpoint);
      err_w       = cfg.invert_error ? -diff_w : diff_w;
      mag_w       = err_w[EW-1] ? unsigned'(-err_w) : unsigned'(err_w);
      in_window_w = MW'(mag_w) < MW'(cfg.integral_window);
      integ_ok_in = (cfg.gain_i != '0) && in_window_w;
   end

   // payload only, valid lives in the top level
   always_ff @(posedge clock) begin
      if (load) begin
         action_ff   <= action;
         err_ff      <= err_w;
         integ_ok_ff <= integ_ok_in;
      end
   end

   assign action_q   = action_ff;
   assign err_q      = err_ff;
   assign integ_ok_q = integ_ok_ff;

endmodule

// File: sv/pmls_core.sv
// loop state, pid sum, clamp, settle stop and the result register
module pmls_core #(
   parameter int SENSOR_WIDTH   = pmls_pkg::SENSOR_WIDTH_DEF,
   parameter int INTEGRAL_WIDTH = pmls_pkg::INTEGRAL_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  pmls_pkg::action_type                   action,
   input  logic signed [SENSOR_WIDTH+1:0]         err,
   input  logic                                   integ_ok,
   input  pmls_pkg::cfg_type                      cfg,
   output logic signed [pmls_pkg::DRIVE_WIDTH-1:0] drive,
   output logic                                   running
);
   import pmls_pkg::*;

   localparam int EW = SENSOR_WIDTH + 2;
   localparam int IW = INTEGRAL_WIDTH;
   localparam int SW = ((IW > EW) ? IW : EW) + 1;
   localparam int PW = EW + GAIN_WIDTH + 1;
   localparam int DW_D = EW + GAIN_WIDTH + 2;
   localparam int IPW = IW + GAIN_WIDTH + 1;
   localparam int DW = (((EW + 10) > (IW + 9)) ? (EW + 10) : (IW + 9)) + 2;

   localparam logic signed [SW-1:0] SUM_MAX = {{(SW-IW+1){1'b0}}, {(IW-1){1'b1}}};
   localparam logic signed [SW-1:0] SUM_MIN = ~SUM_MAX;
   localparam logic signed [IW-1:0] INT_MAX = {1'b0, {(IW-1){1'b1}}};
   localparam logic signed [IW-1:0] INT_MIN = {1'b1, {(IW-1){1'b0}}};

   logic signed [IW-1:0]         integral_ff, integral_in;
   logic signed [EW-1:0]         prev_err_ff, prev_err_in;
   logic [SETTLE_WIDTH-1:0]      settle_ff, settle_in;
   logic                         active_ff, active_in;
   logic signed [DRIVE_WIDTH-1:0] drive_ff, drive_in;
   logic                         running_ff, running_in;

   logic signed [SW-1:0]   isum_w;
   logic signed [IW-1:0]   isat_w;
   logic signed [IW-1:0]   inew_w;
   logic signed [EW:0]     deriv_w;
   logic signed [PW-1:0]   p_term_w;
   logic signed [DW_D-1:0] d_term_w;
   logic signed [IPW-1:0]  i_term_w;
   logic signed [DW-1:0]   pid_w;
   logic signed [DW-1:0]   upper_w;
   logic signed [DW-1:0]   lower_w;
   logic signed [DW-1:0]   hi_clamp_w;
   logic signed [DW-1:0]   clamp_w;
   logic [SETTLE_WIDTH-1:0] settle_next_w;
   logic                   stop_w;

   // integral with saturation, cleared outside the window or when the I gain is zero
   always_comb begin
      isum_w = SW'(integral_ff) + SW'(err);
      if (isum_w > SUM_MAX) begin
         isat_w = INT_MAX;
      end else if (isum_w < SUM_MIN) begin
         isat_w = INT_MIN;
      end else begin
         isat_w = isum_w[IW-1:0];
      end
      inew_w = integ_ok ? isat_w : '0;
   end

   // three products in parallel, then sum and clamp
   always_comb begin
      deriv_w    = (EW+1)'(err) - (EW+1)'(prev_err_ff);
      p_term_w   = PW'($signed({1'b0, cfg.gain_p})) * PW'(err);
      d_term_w   = DW_D'($signed({1'b0, cfg.gain_d})) * DW_D'(deriv_w);
      i_term_w   = IPW'($signed({1'b0, cfg.gain_i})) * IPW'(inew_w);
      pid_w      = DW'(p_term_w) + DW'(d_term_w) + DW'(i_term_w);
      upper_w    = DW'($signed({1'b0, cfg.drive_max}));
      lower_w    = DW'(cfg.drive_min);
      hi_clamp_w = (pid_w > upper_w) ? upper_w : pid_w;
      clamp_w    = (hi_clamp_w < lower_w) ? lower_w : hi_clamp_w;
   end

   // settle counter and stop test
   always_comb begin
      if ((settle_ff <= cfg.settle_ticks) && (settle_ff != SETTLE_COUNT_MAX)) begin
         settle_next_w = settle_ff + 1'b1;
      end else begin
         settle_next_w = settle_ff;
      end
      stop_w = (settle_next_w >= cfg.settle_ticks)
            && (clamp_w <= DW'(STOP_DRIVE_LEVEL));
   end

   always_comb begin
      integral_in = integral_ff;
      prev_err_in = prev_err_ff;
      settle_in   = settle_ff;
      active_in   = active_ff;
      drive_in    = drive_ff;
      running_in  = running_ff;
      if (advance) begin
         if (action == ACTION_START) begin
            active_in  = 1'b1;
            settle_in  = '0;
            drive_in   = '0;
            running_in = 1'b1;
         end else if (!active_ff) begin
            drive_in   = '0;
            running_in = 1'b0;
         end else begin
            integral_in = inew_w;
            prev_err_in = err;
            settle_in   = settle_next_w;
            active_in   = !stop_w;
            drive_in    = clamp_w[DRIVE_WIDTH-1:0];
            running_in  = !stop_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
         prev_err_ff <= '0;
         settle_ff   <= '0;
         active_ff   <= 1'b0;
      end else begin
         integral_ff <= integral_in;
         prev_err_ff <= prev_err_in;
         settle_ff   <= settle_in;
         active_ff   <= active_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      drive_ff   <= drive_in;
      running_ff <= running_in;
   end

   assign drive   = drive_ff;
   assign running = running_ff;

endmodule

// File: sv/pmls_checker.sv
// port-level checks of the pid motor loop and their bind
module pmls_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_stall,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic signed [pmls_pkg::DRIVE_WIDTH-1:0] rsp_drive,
   input logic                                    rsp_running
);
   import pmls_pkg::*;

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive) && $stable(rsp_running))
      else $error("stalled result changed");

   // input only backs up behind a stalled full result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled with result side free");

   // a stopped or idle loop never reports a large drive
   a_stop_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_running |-> rsp_drive <= DRIVE_WIDTH'(STOP_DRIVE_LEVEL))
      else $error("loop stopped with drive above stop level");

endmodule

bind pid_motor_loop_with_settle_stop pmls_checker u_pmls_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_drive   (rsp_drive),
   .rsp_running (rsp_running)
);
